// ----- design/srs_pkg.sv -----
package srs_pkg;

  localparam int DATA_W      = 27;
  localparam int FRAME_W     = 32;
  localparam int ACK_W       = 32;
  localparam int SEQ_W       = 3;
  localparam int SLOTS       = 1 << SEQ_W;
  localparam int PERIOD_W    = 8;
  localparam int WINDOW_DEF  = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [FRAME_W-1:0]  END_FRAME    = 32'h8800_0000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_FINISH  = 2'd3
  } kind_t;

  // classified word handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic [DATA_W-1:0]  payload;
    logic               data_par;
    logic               ack_ok;
    logic [SEQ_W-1:0]   ack_seq;
  } cmd_t;

  // result flags, frame_valid in the lowest bit
  typedef struct packed {
    logic all_acked;
    logic is_retransmission;
    logic accepted;
    logic frame_valid;
  } res_flags_t;

endpackage

// ----- design/selective_repeat_sender.sv -----
// Channel   Dir  Handshake                       Word contents (lowest bit up)
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: payload[26:0], ack_word[58:27]
//                                                tuser: kind[1:0]
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: frame[31:0]
//                                                tuser: frame_valid, accepted,
//                                                       is_retransmission, all_acked
// cfg       in   cfg_we (no wait)                cfg_wdata: retransmit_period[7:0]
//
// One input word yields exactly one output word, passing through the queue and then
// the output register; one word a cycle is sustained while m_axis_tready stays high.
// The back stage updates ack flags, sequence and tick count once per cycle for each
// accepted word, which sets the rate: no kind of word keeps the back stage busy.
// Reset (rst, synchronous) marks every slot acked, clears sequence and tick count,
// empties the queue and loads a retransmit period of two.
// A stall on m_axis holds the output register; the two-entry queue keeps taking
// words until it fills, then s_axis_tready drops.
module selective_repeat_sender #(
  parameter int WINDOW = srs_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave side: tdata = payload[26:0], ack_word[58:27], zeros above
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  // tuser = kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  // master side: tdata = frame[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  // tuser = frame_valid, accepted, is_retransmission, all_acked
  output logic [3:0]  m_axis_tuser,
  // retransmit period register
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int PAY_LO = 0;
  localparam int ACK_LO = srs_pkg::DATA_W;

  logic [srs_pkg::PERIOD_W-1:0] retransmit_period;
  srs_pkg::cmd_t                front_cmd;
  srs_pkg::cmd_t                queue_cmd;
  logic                         queue_valid;
  logic                         queue_ready;
  srs_pkg::res_flags_t          flags;

  // hold the period until the next write
  always_ff @(posedge clk) begin
    if (rst) begin
      retransmit_period <= srs_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      retransmit_period <= cfg_wdata;
    end
  end

  // front: decode kind, check the ack word, fold payload parity
  srs_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .kind     (s_axis_tuser),
    .payload  (s_axis_tdata[PAY_LO +: srs_pkg::DATA_W]),
    .ack_word (s_axis_tdata[ACK_LO +: srs_pkg::ACK_W]),
    .cmd      (front_cmd)
  );

  // short queue: lets the back stall on m_axis without blocking s_axis at once
  srs_queue #(
    .DEPTH (srs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (front_cmd),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_data  (queue_cmd)
  );

  // back: window state, frame store, retransmit timer and output register
  srs_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .period    (retransmit_period),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd       (queue_cmd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_frame (m_axis_tdata),
    .out_flags (flags)
  );

  assign m_axis_tuser = flags;

  // a resend always carries a frame and counts as taken
  a_resend_is_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[0] && m_axis_tuser[1])
    else $error("resend without frame or acceptance");

  // the end frame leaves only with every slot acked
  a_end_all_acked: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[27] |-> m_axis_tuser[3])
    else $error("end frame while frames pending");

  // no word comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid straight after reset");

endmodule

// ----- design/srs_front.sv -----
module srs_front #(
  parameter int WINDOW = srs_pkg::WINDOW_DEF
) (
  input  logic [1:0]                 kind,
  input  logic [srs_pkg::DATA_W-1:0] payload,
  input  logic [srs_pkg::ACK_W-1:0]  ack_word,
  output srs_pkg::cmd_t              cmd
);

  localparam logic [srs_pkg::SEQ_W:0] MOD = (srs_pkg::SEQ_W + 1)'(2 * WINDOW);

  logic parity_even;
  logic high_clear;
  logic seq_in_range;

  assign parity_even  = ~(^ack_word);
  assign high_clear   = (ack_word[srs_pkg::ACK_W-1:srs_pkg::SEQ_W+1] == '0);
  assign seq_in_range = ({1'b0, ack_word[srs_pkg::SEQ_W:1]} < MOD);

  always_comb begin
    cmd.kind     = srs_pkg::kind_t'(kind);
    cmd.payload  = payload;
    cmd.data_par = ^payload;
    cmd.ack_ok   = parity_even && high_clear && seq_in_range;
    cmd.ack_seq  = ack_word[srs_pkg::SEQ_W:1];
  end

endmodule

// ----- design/srs_queue.sv -----
module srs_queue #(
  parameter int DEPTH = srs_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  srs_pkg::cmd_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output srs_pkg::cmd_t out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  srs_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != FULL);
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- design/srs_back.sv -----
module srs_back #(
  parameter int WINDOW = srs_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [srs_pkg::PERIOD_W-1:0]    period,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  srs_pkg::cmd_t                   cmd,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [srs_pkg::FRAME_W-1:0]     out_frame,
  output srs_pkg::res_flags_t             out_flags
);

  localparam int SW = srs_pkg::SEQ_W;
  localparam logic [SW:0]   MOD     = (SW + 1)'(2 * WINDOW);
  localparam logic [SW-1:0] W_SEQ   = SW'(WINDOW);
  localparam logic [SW-1:0] SEQ_TOP = SW'(2 * WINDOW - 1);

  logic [srs_pkg::FRAME_W-1:0]  frames [srs_pkg::SLOTS];
  logic [srs_pkg::SLOTS-1:0]    acked;
  logic [srs_pkg::SLOTS-1:0]    acked_next;
  logic [SW-1:0]                next_seq;
  logic [SW-1:0]                next_seq_next;
  logic [srs_pkg::PERIOD_W-1:0] tick_count;
  logic [srs_pkg::PERIOD_W-1:0] tick_count_next;

  logic                         fire;
  logic [SW-1:0]                base;
  logic                         found;
  logic [SW-1:0]                oldest;
  logic [srs_pkg::FRAME_W-1:0]  new_frame;
  logic                         store;
  logic [srs_pkg::PERIOD_W-1:0] period_eff;
  logic [srs_pkg::PERIOD_W-1:0] tick_inc;
  logic [srs_pkg::FRAME_W-1:0]  res_frame;
  srs_pkg::res_flags_t          res_flags;

  assign cmd_ready = !out_valid || out_ready;
  assign fire      = cmd_valid && cmd_ready;

  // slot WINDOW sequence numbers back, also the oldest one in flight
  assign base = (next_seq >= W_SEQ) ? next_seq - W_SEQ : next_seq + W_SEQ;

  assign new_frame = {cmd.data_par ^ (^next_seq), next_seq, 1'b0, cmd.payload};

  assign period_eff = (period == '0) ? srs_pkg::PERIOD_W'(1) : period;
  assign tick_inc   = tick_count + srs_pkg::PERIOD_W'(1);

  // oldest unacked slot among the window, lowest offset wins
  always_comb begin
    logic [SW:0] cand;
    found  = 1'b0;
    oldest = base;
    cand   = '0;
    for (int i = WINDOW - 1; i >= 0; i--) begin
      cand = {1'b0, base} + (SW + 1)'(i);
      if (cand >= MOD) begin
        cand = cand - MOD;
      end
      if (!acked[cand[SW-1:0]]) begin
        found  = 1'b1;
        oldest = cand[SW-1:0];
      end
    end
  end

  always_comb begin
    acked_next      = acked;
    next_seq_next   = next_seq;
    tick_count_next = tick_count;
    store           = 1'b0;
    res_frame       = '0;
    res_flags       = '0;
    unique case (cmd.kind)
      srs_pkg::KIND_PAYLOAD: begin
        if (acked[base]) begin
          store                 = 1'b1;
          acked_next[next_seq]  = 1'b0;
          next_seq_next         = (next_seq == SEQ_TOP) ? '0 : next_seq + SW'(1);
          res_frame             = new_frame;
          res_flags.frame_valid = 1'b1;
          res_flags.accepted    = 1'b1;
        end
      end
      srs_pkg::KIND_ACK: begin
        if (cmd.ack_ok) begin
          acked_next[cmd.ack_seq] = 1'b1;
          res_flags.accepted      = 1'b1;
        end
      end
      srs_pkg::KIND_TICK: begin
        res_flags.accepted = 1'b1;
        tick_count_next    = tick_inc;
        if (tick_inc >= period_eff) begin
          tick_count_next = '0;
          if (found) begin
            res_frame                   = frames[oldest];
            res_flags.frame_valid       = 1'b1;
            res_flags.is_retransmission = 1'b1;
          end
        end
      end
      srs_pkg::KIND_FINISH: begin
        if (&acked) begin
          res_frame             = srs_pkg::END_FRAME;
          res_flags.frame_valid = 1'b1;
          res_flags.accepted    = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // slots past the modulus are never cleared, so the whole vector serves
    res_flags.all_acked = &acked_next;
  end

  always_ff @(posedge clk) begin
    if (fire && store) begin
      frames[next_seq] <= new_frame;
    end
    if (fire) begin
      out_frame <= res_frame;
      out_flags <= res_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acked      <= '1;
      next_seq   <= '0;
      tick_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        acked      <= acked_next;
        next_seq   <= next_seq_next;
        tick_count <= tick_count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
